[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: cons must hold in the same cycle as ante.
`define SPVG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define SPVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spvg_pkg.sv]
package spvg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF   = 31;
  localparam int CORDIC_STEPS_DEF = 24;

  // Iteration counts of the setup units
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 25;

  // Binary angle constants (full turn = 2^24)
  localparam logic signed [25:0] HALF_TURN    = 26'sd8388608;
  localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;

  // 1/CORDIC gain in Q30
  localparam logic [29:0] INV_GAIN = 30'd652032874;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       sq_first;
    logic       sq_add;
    logic       sq_inner;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       sqrt_store;
    logic       div_init;
    logic       div_step;
    logic       k_init;
    logic       k_adv;
    logic       vec_init;
    logic       vec_store;
    logic       rot_init;
    logic       rot_odd;
    logic       cor_step;
    logic       round;
    logic       emit;
    logic       close;
    logic [4:0] idx;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       out_free;
    logic       outer_zero;
    logic [5:0] n2;
  } sts_t;

  // atan(2^-i) in binary angle units
  function automatic logic [21:0] atan_val(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2097152;
      5'd1:    v = 22'd1238021;
      5'd2:    v = 22'd654136;
      5'd3:    v = 22'd332050;
      5'd4:    v = 22'd166669;
      5'd5:    v = 22'd83416;
      5'd6:    v = 22'd41718;
      5'd7:    v = 22'd20860;
      5'd8:    v = 22'd10430;
      5'd9:    v = 22'd5215;
      5'd10:   v = 22'd2608;
      5'd11:   v = 22'd1304;
      5'd12:   v = 22'd652;
      5'd13:   v = 22'd326;
      5'd14:   v = 22'd163;
      5'd15:   v = 22'd81;
      5'd16:   v = 22'd41;
      5'd17:   v = 22'd20;
      5'd18:   v = 22'd10;
      5'd19:   v = 22'd5;
      5'd20:   v = 22'd3;
      5'd21:   v = 22'd1;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/spvg_ctrl.sv]
`include "assert_macros.svh"

module spvg_ctrl #(
  parameter int CORDIC_STEPS = spvg_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  spvg_pkg::sts_t  sts,
  output spvg_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SQ_A      = 4'd1;
  localparam logic [3:0] S_SQ_B      = 4'd2;
  localparam logic [3:0] S_SQRT_INIT = 4'd3;
  localparam logic [3:0] S_SQRT      = 4'd4;
  localparam logic [3:0] S_SQRT_END  = 4'd5;
  localparam logic [3:0] S_DIV_INIT  = 4'd6;
  localparam logic [3:0] S_DIV       = 4'd7;
  localparam logic [3:0] S_VEC_INIT  = 4'd8;
  localparam logic [3:0] S_VEC       = 4'd9;
  localparam logic [3:0] S_VEC_END   = 4'd10;
  localparam logic [3:0] S_ROT_INIT  = 4'd11;
  localparam logic [3:0] S_ROT       = 4'd12;
  localparam logic [3:0] S_ROUND     = 4'd13;
  localparam logic [3:0] S_EMIT      = 4'd14;
  localparam logic [3:0] S_CLOSE     = 4'd15;

  localparam logic [5:0] COR_LAST  = 6'(CORDIC_STEPS - 1);
  localparam logic [5:0] SQRT_LAST = 6'(spvg_pkg::SQRT_STEPS - 1);
  localparam logic [5:0] DIV_LAST  = 6'(spvg_pkg::DIV_STEPS - 1);

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [5:0] k, k_next;
  logic       inner, inner_next;

  assign in_stall = (state != S_IDLE);

  // Sequence the setup units, then one rotation per vertex
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    inner_next = inner;
    cmd        = '0;
    cmd.idx    = cnt[4:0];
    cmd.sq_inner = inner;
    cmd.rot_odd  = k[0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          inner_next = 1'b0;
          state_next = S_SQ_A;
        end
      end
      S_SQ_A: begin
        cmd.sq_first = 1'b1;
        state_next   = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.sq_add = 1'b1;
        state_next = S_SQRT_INIT;
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 6'd1;
        if (cnt == SQRT_LAST) state_next = S_SQRT_END;
      end
      S_SQRT_END: begin
        cmd.sqrt_store = 1'b1;
        if (inner) begin
          state_next = S_DIV_INIT;
        end else begin
          inner_next = 1'b1;
          state_next = S_SQ_A;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cmd.k_init   = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == DIV_LAST) state_next = S_VEC_INIT;
      end
      S_VEC_INIT: begin
        cmd.vec_init = 1'b1;
        cnt_next     = '0;
        k_next       = '0;
        state_next   = sts.outer_zero ? S_ROT_INIT : S_VEC;
      end
      S_VEC: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == COR_LAST) state_next = S_VEC_END;
      end
      S_VEC_END: begin
        cmd.vec_store = 1'b1;
        state_next    = S_ROT_INIT;
      end
      S_ROT_INIT: begin
        cmd.rot_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_ROT;
      end
      S_ROT: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == COR_LAST) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the item
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (k == sts.n2 - 6'd1) begin
            state_next = S_CLOSE;
          end else begin
            cmd.k_adv  = 1'b1;
            k_next     = k + 6'd1;
            state_next = S_ROT_INIT;
          end
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.close  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      k     <= '0;
      inner <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      inner <= inner_next;
    end
  end

  `SPVG_ASSERT_IMPL(a_k_range, state == S_ROT, k < sts.n2, "vertex index past 2N")
  `SPVG_ASSERT_IMPL(a_cnt_range, state == S_ROT || state == S_VEC,
                    cnt <= COR_LAST, "CORDIC step count overrun")
  `SPVG_ASSERT_NEXT(a_close_idle, state == S_CLOSE && sts.out_free,
                    state == S_IDLE, "closing item did not end the star")

endmodule

[rtl/core/spvg_dp.sv]
`include "assert_macros.svh"

module spvg_dp #(
  parameter int MAX_POINTS = spvg_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  spvg_pkg::cmd_t      cmd,
  output spvg_pkg::sts_t      sts,
  input  logic signed [14:0]  center_x,
  input  logic signed [14:0]  center_y,
  input  logic signed [14:0]  outer_x,
  input  logic signed [14:0]  outer_y,
  input  logic signed [14:0]  inner_x,
  input  logic signed [14:0]  inner_y,
  input  logic        [4:0]   num_points,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  vertex_x,
  output logic signed [16:0]  vertex_y,
  output logic                is_last,
  output logic signed [16:0]  box_min_x,
  output logic signed [16:0]  box_min_y,
  output logic signed [16:0]  box_max_x,
  output logic signed [16:0]  box_max_y
);

  localparam logic [4:0] NMAX = 5'(MAX_POINTS);
  localparam logic [37:0] HALF_LSB = 38'h2000000000;

  // Item registers
  logic signed [14:0] cx, cy;
  logic signed [15:0] dxo, dyo, dxi, dyi;
  logic [4:0]         n;
  logic [5:0]         n2;

  // Radius units
  logic signed [15:0] mop;
  logic signed [31:0] prod;
  logic [31:0]        acc;
  logic [47:0]        sv, sr, sb, strial;
  logic [23:0]        ro, ri;

  // Divider and angle stepping
  logic [24:0] dn, dq;
  logic [6:0]  drem, rsh, s2;
  logic [23:0] stq, off;
  logic [6:0]  str;

  // CORDIC
  logic signed [57:0] xr, yr, xs, ys, ex, ey;
  logic signed [25:0] zr, at, t, tf;
  logic               vmode, flip, dpos, tflip;
  logic [23:0]        ang, rr;
  logic [53:0]        rmul;

  // Rounding and tracking
  logic signed [57:0] ox, oy, totx, toty;
  logic signed [19:0] vx, vy, qx, qy;
  logic signed [19:0] lx, ly, fx, fy, bx0, by0, bx1, by1;
  logic               have, dup, out_free, load_v;

  assign n2 = {n, 1'b0};
  assign out_free = !out_valid || !out_stall;
  assign sts.out_free   = out_free;
  assign sts.outer_zero = (dxo == 16'sd0) && (dyo == 16'sd0);
  assign sts.n2         = n2;

  // Latch the item and clamp the point count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx  <= center_x;
      cy  <= center_y;
      dxo <= {outer_x[14], outer_x} - {center_x[14], center_x};
      dyo <= {outer_y[14], outer_y} - {center_y[14], center_y};
      dxi <= {inner_x[14], inner_x} - {center_x[14], center_x};
      dyi <= {inner_y[14], inner_y} - {center_y[14], center_y};
      if (num_points > NMAX)       n <= NMAX;
      else if (num_points < 5'd3)  n <= 5'd3;
      else                         n <= num_points;
    end
  end

  // Squared length, one product a cycle
  always_comb begin
    if (cmd.sq_add) mop = cmd.sq_inner ? dyi : dyo;
    else            mop = cmd.sq_inner ? dxi : dxo;
  end
  assign prod = mop * mop;

  always_ff @(posedge clk) begin
    if (cmd.sq_first)    acc <= unsigned'(prod);
    else if (cmd.sq_add) acc <= acc + unsigned'(prod);
  end

  // Bitwise integer square root
  assign strial = sr + sb;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sv <= {acc, 16'd0};
      sr <= '0;
      sb <= 48'd1 << 46;
    end else if (cmd.sqrt_step) begin
      if (sv >= strial) begin
        sv <= sv - strial;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end
    if (cmd.sqrt_store) begin
      if (cmd.sq_inner) ri <= sr[23:0];
      else              ro <= sr[23:0];
    end
  end

  // Restoring divide of a full turn by 2N, one bit a cycle
  assign rsh = {drem[5:0], dn[24]};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dn   <= 25'h1000000;
      drem <= '0;
      dq   <= '0;
    end else if (cmd.div_step) begin
      dn <= dn << 1;
      if (rsh >= {1'b0, n2}) begin
        drem <= rsh - {1'b0, n2};
        dq   <= {dq[23:0], 1'b1};
      end else begin
        drem <= rsh;
        dq   <= {dq[23:0], 1'b0};
      end
    end
  end

  // Advance the rounded vertex angle step by quotient and remainder
  assign s2 = str + drem;
  always_ff @(posedge clk) begin
    if (cmd.k_init) begin
      stq <= '0;
      str <= {2'b00, n};
    end else if (cmd.k_adv) begin
      if (s2 >= {1'b0, n2}) begin
        str <= s2 - {1'b0, n2};
        stq <= stq + dq[23:0] + 24'd1;
      end else begin
        str <= s2;
        stq <= stq + dq[23:0];
      end
    end
  end

  // Fold the vertex angle into the right half plane
  assign ang = off + stq;
  always_comb begin
    t     = {{2{ang[23]}}, ang};
    tf    = t;
    tflip = 1'b0;
    if (t > spvg_pkg::QUARTER_TURN) begin
      tf    = t - spvg_pkg::HALF_TURN;
      tflip = 1'b1;
    end else if (t < -spvg_pkg::QUARTER_TURN) begin
      tf    = t + spvg_pkg::HALF_TURN;
      tflip = 1'b1;
    end
  end

  assign rr   = cmd.rot_odd ? ri : ro;
  assign rmul = 54'(rr) * 54'(spvg_pkg::INV_GAIN);

  assign ex = {{26{dxo[15]}}, dxo, 16'd0};
  assign ey = {{26{dyo[15]}}, dyo, 16'd0};
  assign xs = xr >>> cmd.idx;
  assign ys = yr >>> cmd.idx;
  assign at = signed'({4'd0, spvg_pkg::atan_val(cmd.idx)});
  assign dpos = vmode ? !(yr > 58'sd0) : !zr[25];

  // Shared CORDIC: vectoring for the start angle, rotation per vertex
  always_ff @(posedge clk) begin
    if (cmd.vec_init) begin
      vmode <= 1'b1;
      off   <= '0;
      if (dxo < 16'sd0) begin
        xr <= -ex;
        yr <= -ey;
        zr <= spvg_pkg::HALF_TURN;
      end else begin
        xr <= ex;
        yr <= ey;
        zr <= '0;
      end
    end else if (cmd.rot_init) begin
      vmode <= 1'b0;
      flip  <= tflip;
      xr    <= signed'({4'd0, rmul});
      yr    <= '0;
      zr    <= tf;
    end else if (cmd.cor_step) begin
      if (dpos) begin
        xr <= xr - ys;
        yr <= yr + xs;
        zr <= zr - at;
      end else begin
        xr <= xr + ys;
        yr <= yr - xs;
        zr <= zr + at;
      end
    end
    if (cmd.vec_store) off <= zr[23:0];
  end

  // Add the center and round to nearest, ties to even
  assign ox   = flip ? -xr : xr;
  assign oy   = flip ? -yr : yr;
  assign totx = {{5{cx[14]}}, cx, 38'd0} + ox;
  assign toty = {{5{cy[14]}}, cy, 38'd0} + oy;
  always_comb begin
    qx = totx[57:38];
    qy = toty[57:38];
    if (totx[37:0] > HALF_LSB || (totx[37:0] == HALF_LSB && qx[0])) qx = qx + 20'sd1;
    if (toty[37:0] > HALF_LSB || (toty[37:0] == HALF_LSB && qy[0])) qy = qy + 20'sd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      vx <= qx;
      vy <= qy;
    end
  end

  assign dup    = have && (vx == lx) && (vy == ly);
  assign load_v = (cmd.emit && !dup) || cmd.close;

  // Track the last vertex, the first one and the bounding box
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.load) begin
      have <= 1'b0;
    end else if (cmd.emit && !dup) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && !dup) begin
      lx <= vx;
      ly <= vy;
      if (!have) begin
        fx  <= vx;
        fy  <= vy;
        bx0 <= vx;
        by0 <= vy;
        bx1 <= vx;
        by1 <= vy;
      end else begin
        if (vx < bx0) bx0 <= vx;
        if (vy < by0) by0 <= vy;
        if (vx > bx1) bx1 <= vx;
        if (vy > by1) by1 <= vy;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_v) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      vertex_x  <= fx[16:0];
      vertex_y  <= fy[16:0];
      is_last   <= 1'b1;
      box_min_x <= bx0[16:0];
      box_min_y <= by0[16:0];
      box_max_x <= bx1[16:0];
      box_max_y <= by1[16:0];
    end else if (cmd.emit && !dup) begin
      vertex_x  <= vx[16:0];
      vertex_y  <= vy[16:0];
      is_last   <= 1'b0;
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
    end
  end

  `SPVG_ASSERT_NEXT(a_emit_have, cmd.emit, have, "emitted vertex not recorded")
  `SPVG_ASSERT_IMPL(a_box_order, have, bx0 <= bx1 && by0 <= by1, "bounding box inverted")
  `SPVG_ASSERT_IMPL(a_close_have, cmd.close, have, "closing item without any vertex")

endmodule

[rtl/core/star_polygon_vertex_generator.sv]
// Star polygon vertex generator. One input item (center, outer point, inner point,
// point count N clamped to 3..MAX_POINTS) yields up to 2N vertices alternating
// between outer and inner radius, each rounded ties-to-even, with repeats of the
// previous vertex dropped, then a closing copy of the first vertex flagged is_last
// that carries the bounding box. Items are handled one at a time. The single iterative
// CORDIC unit, used for the start angle and once per vertex, runs after two square
// roots (outer and inner radius) and a divide of a full turn by 2N for the angle step.
module star_polygon_vertex_generator #(
  parameter int MAX_POINTS   = spvg_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = spvg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] center_x,
  input  logic signed [14:0] center_y,
  input  logic signed [14:0] outer_x,
  input  logic signed [14:0] outer_y,
  input  logic signed [14:0] inner_x,
  input  logic signed [14:0] inner_y,
  input  logic        [4:0]  num_points,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] vertex_x,
  output logic signed [16:0] vertex_y,
  output logic               is_last,
  output logic signed [16:0] box_min_x,
  output logic signed [16:0] box_min_y,
  output logic signed [16:0] box_max_x,
  output logic signed [16:0] box_max_y
);

  spvg_pkg::cmd_t cmd;
  spvg_pkg::sts_t sts;

  spvg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spvg_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .center_x   (center_x),
    .center_y   (center_y),
    .outer_x    (outer_x),
    .outer_y    (outer_y),
    .inner_x    (inner_x),
    .inner_y    (inner_y),
    .num_points (num_points),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .is_last    (is_last),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y)
  );

endmodule
